FILE: sv/udc_pkg.sv
// ----------------------------------------------------------------------------
// udc_pkg: shared types and constants of the baud divisor calculator
// Widths, status codes, register index and pipeline stage records.
// ----------------------------------------------------------------------------
package udc_pkg;

   localparam int CLOCK_BITS  = 27;
   localparam int BAUD_W      = 24;
   localparam int DEN_W       = BAUD_W + 4;          // baud times 16 at most
   localparam int REM100_W    = 7;                   // remainder in hundredths
   localparam int PROD_W      = DEN_W + REM100_W;    // remainder times 100
   localparam int MANT_W      = 12;
   localparam int FRAC_W      = 4;
   localparam int WORD_W      = MANT_W + FRAC_W;
   localparam int STATUS_W    = 2;
   localparam int X_W         = 12;                  // hundredths times steps plus half
   localparam int RECIP_W     = 6;
   localparam int RECIP_SHIFT = 12;
   localparam int XP_W        = X_W + 5;             // x times reciprocal
   localparam int QEST_W      = XP_W - RECIP_SHIFT;
   localparam int QPROD_W     = X_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [REM100_W-1:0] HUNDRED   = 7'd100;
   localparam logic [5:0]          HALF      = 6'd50;
   localparam logic [RECIP_W-1:0]  RECIP_100 = 6'd41;   // 41/4096, just above 1/100
   localparam logic [MANT_W-1:0]   MANT_MAX  = 12'hFFF;
   localparam logic [FRAC_W-1:0]   FRAC_MASK_BY8  = 4'h7;
   localparam logic [FRAC_W-1:0]   FRAC_MASK_BY16 = 4'hF;
   localparam logic [4:0]          STEPS_BY8  = 5'd8;
   localparam logic [4:0]          STEPS_BY16 = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_OVERSAMPLE = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_BAUD = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   // one word moving through the restoring divider
   typedef struct packed {
      logic                  valid;
      logic                  by8;
      logic                  zero;
      logic [DEN_W-1:0]      den;
      logic [DEN_W-1:0]      rem;
      logic [CLOCK_BITS-1:0] bits;
      logic [CLOCK_BITS-1:0] quot;
      logic [CLOCK_BITS-1:0] mant;
   } div_type;

   // one word in the rounding stage
   typedef struct packed {
      logic                  valid;
      logic                  by8;
      logic                  zero;
      logic [CLOCK_BITS-1:0] mant;
      logic [X_W-1:0]        x;
      logic [QEST_W-1:0]     qest;
   } round_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] divisor_word;
      status_type        status;
   } rsp_type;

endpackage

FILE: sv/udc_if.sv
// ----------------------------------------------------------------------------
// udc_if: request and response channels of the baud divisor calculator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface udc_req_if import udc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CLOCK_BITS-1:0] clock_hz;
   logic [BAUD_W-1:0]     baud_rate;

   modport source (output valid, clock_hz, baud_rate, input ready);
   modport sink   (input valid, clock_hz, baud_rate, output ready);
endinterface

interface udc_rsp_if import udc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   divisor_word;
   logic [STATUS_W-1:0] status;

   modport source (output valid, divisor_word, status, input ready);
   modport sink   (input valid, divisor_word, status, output ready);
endinterface

FILE: sv/udc_div_step.sv
// ----------------------------------------------------------------------------
// udc_div_step: one restoring division stage
// Shift in one dividend bit, subtract the divisor where it fits, register.
// ----------------------------------------------------------------------------
module udc_div_step import udc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  div_type stage_i,
   output div_type stage_o
);

   div_type           stage_ff;
   div_type           stage_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   always_comb begin
      trial    = {stage_i.rem, stage_i.bits[CLOCK_BITS-1]};
      diff     = trial - {1'b0, stage_i.den};
      fits     = (trial >= {1'b0, stage_i.den});
      stage_in = stage_i;
      stage_in.rem  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      stage_in.bits = {stage_i.bits[CLOCK_BITS-2:0], 1'b0};
      stage_in.quot = {stage_i.quot[CLOCK_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

FILE: sv/udc_scale.sv
// ----------------------------------------------------------------------------
// udc_scale: turn the integer remainder into a hundredths division
// Latch the mantissa, scale the remainder by 100 and reload the divider.
// ----------------------------------------------------------------------------
module udc_scale import udc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  div_type stage_i,
   output div_type stage_o
);

   div_type            stage_ff;
   div_type            stage_in;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      prod     = {{REM100_W{1'b0}}, stage_i.rem} * PROD_W'(HUNDRED);
      stage_in = stage_i;
      stage_in.mant = stage_i.quot;
      // top part is already below the divisor, the low seven bits shift in
      stage_in.rem  = prod[PROD_W-1:REM100_W];
      stage_in.bits = {prod[REM100_W-1:0], {(CLOCK_BITS-REM100_W){1'b0}}};
      stage_in.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

FILE: sv/udc_round.sv
// ----------------------------------------------------------------------------
// udc_round: round the fraction, carry, saturate and pack the divisor word
// Two stages: reciprocal estimate of the fraction, then correction and pack.
// ----------------------------------------------------------------------------
module udc_round import udc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  div_type stage_i,
   output rsp_type rsp_o
);

   round_type             rnd_ff;
   round_type             rnd_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [REM100_W-1:0]   rem100;
   logic [XP_W-1:0]       xprod;
   logic [QPROD_W-1:0]    qprod;
   logic [QEST_W-1:0]     q;
   logic [4:0]            steps;
   logic                  full;
   logic [FRAC_W-1:0]     frac;
   logic [CLOCK_BITS:0]   mant_c;
   logic                  sat;

   // estimate (hundredths * steps + 50) / 100, never low, at most one high
   always_comb begin
      rem100 = stage_i.quot[REM100_W-1:0];
      rnd_in.valid = stage_i.valid;
      rnd_in.by8   = stage_i.by8;
      rnd_in.zero  = stage_i.zero;
      rnd_in.mant  = stage_i.mant;
      if (stage_i.by8) begin
         rnd_in.x = (X_W'(rem100) << 3) + X_W'(HALF);
      end else begin
         rnd_in.x = (X_W'(rem100) << 4) + X_W'(HALF);
      end
      xprod       = XP_W'(rnd_in.x) * XP_W'(RECIP_100);
      rnd_in.qest = xprod[XP_W-1:RECIP_SHIFT];
   end

   always_comb begin
      qprod  = QPROD_W'(rnd_ff.qest) * QPROD_W'(HUNDRED);
      q      = (qprod > rnd_ff.x) ? rnd_ff.qest - QEST_W'(1) : rnd_ff.qest;
      steps  = rnd_ff.by8 ? STEPS_BY8 : STEPS_BY16;
      full   = (5'(q) >= steps);
      frac   = full ? '0 : q[FRAC_W-1:0];
      mant_c = {1'b0, rnd_ff.mant} + (CLOCK_BITS+1)'(full);
      sat    = (mant_c > (CLOCK_BITS+1)'(MANT_MAX));
      rsp_in.valid = rnd_ff.valid;
      if (rnd_ff.zero) begin
         rsp_in.divisor_word = '0;
         rsp_in.status       = STATUS_ZERO_BAUD;
      end else if (sat) begin
         rsp_in.divisor_word = {MANT_MAX, rnd_ff.by8 ? FRAC_MASK_BY8 : FRAC_MASK_BY16};
         rsp_in.status       = STATUS_SATURATED;
      end else begin
         rsp_in.divisor_word = {mant_c[MANT_W-1:0], frac};
         rsp_in.status       = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.valid <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else if (en) begin
         rnd_ff <= rnd_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

endmodule

FILE: sv/uart_baud_divisor_calc_core.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core: USART fractional baud rate divisor calculator
// Pipelined divider that packs a 12-bit mantissa and rounded fraction.
// ----------------------------------------------------------------------------
// Each request word carries a clock frequency and a baud rate; each returns
// exactly one response word with the packed divisor and a status code. The
// block accepts one word per clock while the response side does not stall,
// and each word passes through one entry register, 27 restoring division
// stages that each resolve one mantissa bit (clock / (8 or 16 * baud)), one
// stage that scales the remainder by 100, 7 more division stages for the
// hundredths, and two rounding and packing stages, the last of which is the
// output register. The division stages resolve one quotient bit per stage. When
// the response side stalls, the whole pipeline freezes and holds every word
// in flight. The oversampling register is sampled as a word enters, so write
// it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core import udc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   udc_req_if.sink               req_ch,
   udc_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STAGES = CLOCK_BITS + REM100_W;

   logic    by8_ff;
   logic    by8_in;
   logic    csr_write;
   logic    en;
   div_type entry_ff;
   div_type entry_in;
   div_type int_stg [0:CLOCK_BITS];
   div_type frac_stg [0:REM100_W];
   rsp_type rsp;

   // ---------------------------------------------------------------
   // configuration register: oversampling by 8 when set
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_OVERSAMPLE);

   always_comb begin
      by8_in = csr_write ? csr_pwdata[0] : by8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         by8_ff <= 1'b0;
      end else begin
         by8_ff <= by8_in;
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_OVERSAMPLE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, by8_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ---------------------------------------------------------------
   // global advance: move every stage when the output slot frees up
   // ---------------------------------------------------------------
   assign en           = !rsp.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // entry: form the divisor (baud times 8 or 16) and flag a zero baud
   always_comb begin
      entry_in.valid = req_ch.valid;
      entry_in.by8   = by8_ff;
      entry_in.zero  = (req_ch.baud_rate == '0);
      if (by8_ff) begin
         entry_in.den = DEN_W'(req_ch.baud_rate) << 3;
      end else begin
         entry_in.den = DEN_W'(req_ch.baud_rate) << 4;
      end
      entry_in.rem  = '0;
      entry_in.bits = req_ch.clock_hz;
      entry_in.quot = '0;
      entry_in.mant = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (en) begin
         entry_ff <= entry_in;
      end
   end

   // mantissa: one quotient bit per stage
   assign int_stg[0] = entry_ff;

   for (genvar i = 0; i < CLOCK_BITS; i++) begin : g_int
      udc_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .stage_i (int_stg[i]),
         .stage_o (int_stg[i+1])
      );
   end

   // reload the divider with the remainder times 100
   udc_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .stage_i (int_stg[CLOCK_BITS]),
      .stage_o (frac_stg[0])
   );

   // hundredths: seven more quotient bits
   for (genvar j = 0; j < REM100_W; j++) begin : g_frac
      udc_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .stage_i (frac_stg[j]),
         .stage_o (frac_stg[j+1])
      );
   end

   // round, carry into the mantissa, saturate and pack
   udc_round u_round (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .stage_i (frac_stg[REM100_W]),
      .rsp_o   (rsp)
   );

   assign rsp_ch.valid        = rsp.valid;
   assign rsp_ch.divisor_word = rsp.divisor_word;
   assign rsp_ch.status       = rsp.status;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   a_stall_blocks_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while the output is stalled (%0d stages)", STAGES);

   a_zero_baud_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_ZERO_BAUD) |-> (rsp_ch.divisor_word == '0))
      else $error("zero baud rate gave a nonzero divisor word");

   a_saturated_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_SATURATED) |->
      (rsp_ch.divisor_word[WORD_W-1:FRAC_W] == MANT_MAX))
      else $error("saturated status without full mantissa");

   a_by8_fraction: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && by8_ff && rsp_ch.status != STATUS_ZERO_BAUD) |->
      !rsp_ch.divisor_word[FRAC_W-1])
      else $error("fraction overflowed three bits when oversampling by 8");

endmodule
